@@ design/lrc_pkg.sv @@
// Shared types and codes for the log record CRC checker.
// No dependencies; imported by every module of the block.
package lrc_pkg;

    localparam int unsigned HDR_BYTES   = 8;
    localparam int unsigned CHK_BYTES   = 4;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'h82F6_3B78;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EOL     = 2'd1,
        ST_CORRUPT = 2'd2
    } status_t;

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } in_word_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       record_done;
        status_t    status;
    } result_t;

endpackage

@@ design/log_record_crc_checker_top.sv @@
// Top level of the log record CRC checker.
// Depends on lrc_pkg, lrc_in_stage, lrc_parse and lrc_out_stage.
//
// Usage:
//   Slave channel s_axis carries the log stream, one byte per word in tdata;
//   tlast set marks end of stream and the byte is then ignored.
//   Master channel m_axis gives payload bytes in tdata, tuser[0] set when
//   tdata holds a payload byte, tlast set at the end of a record or stream
//   with tuser[2:1] holding the status (0 ok, 1 end of log, 2 corruption).
//   Header bytes give no word, except the last header byte of a zero-length
//   record, which gives a status word.
//   A word accepted into the input register is parsed on its way into the
//   result register and is on m_axis from there. Throughput: one word per
//   cycle while the receiver does not stall, set by the byte-wide CRC-32C
//   update and length count between the input and result registers.
//   Reset clears both registers and puts the parser at the start of a header.
//   When the receiver stalls, the result word holds and the input register,
//   once full, holds its word; s_axis_tready then falls with m_axis_tready.
module log_record_crc_checker_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_marker
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0] m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic       m_axis_tlast    // record_done
);
    import lrc_pkg::*;

    in_word_t s_word;
    in_word_t word;
    logic     word_valid;
    logic     out_free;
    logic     take;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_word.data_byte  = s_axis_tdata;
    assign s_word.end_marker = s_axis_tlast;
    assign take              = word_valid && out_free;

    lrc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_word     (s_word),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    lrc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (take),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    lrc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (m_res)
    );

    assign m_axis_tdata = m_res.payload_byte;
    assign m_axis_tuser = {m_res.status, m_res.byte_valid};
    assign m_axis_tlast = m_res.record_done;

endmodule

@@ design/lrc_in_stage.sv @@
// Input register for the log record CRC checker: holds one incoming word.
// Depends on lrc_pkg.
module lrc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  lrc_pkg::in_word_t s_word,
    input  logic              take,
    output logic              word_valid,
    output lrc_pkg::in_word_t word
);
    import lrc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    assign s_ready    = !valid_reg || take;
    assign load       = s_valid && s_ready;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= s_word;
        end
    end

endmodule

@@ design/lrc_parse.sv @@
// Record parser: header capture, length count and CRC-32C over the payload.
// Depends on lrc_pkg.
module lrc_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  lrc_pkg::in_word_t word,
    output logic              res_valid,
    output lrc_pkg::result_t  res
);
    import lrc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] chk_reg, chk_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crc_upd;
    logic [31:0] full_len;
    logic        hdr_last;
    logic        pay_last;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign crc_upd  = crc32c_byte(crc_reg, word.data_byte);
    assign full_len = {word.data_byte, left_reg[23:0]};
    assign hdr_last = (hdr_cnt_reg == 3'(HDR_BYTES - 1));
    assign pay_last = (left_reg == 32'd1);

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        chk_next     = chk_reg;
        left_next    = left_reg;
        crc_next     = crc_reg;
        if (fire)
        begin
            if (word.end_marker)
            begin
                phase_next   = PH_HEADER;
                hdr_cnt_next = '0;
                chk_next     = '0;
                left_next    = '0;
                crc_next     = CRC_INIT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        if (hdr_cnt_reg < 3'(CHK_BYTES))
                        begin
                            chk_next[{hdr_cnt_reg[1:0], 3'b000} +: 8] = word.data_byte;
                        end
                        else
                        begin
                            left_next[{hdr_cnt_reg[1:0], 3'b000} +: 8] = word.data_byte;
                        end
                        if (hdr_last)
                        begin
                            crc_next = CRC_INIT;
                            if (full_len == 32'd0)
                            begin
                                chk_next  = '0;
                                left_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        crc_next  = crc_upd;
                        left_next = left_reg - 32'd1;
                        if (pay_last)
                        begin
                            phase_next = PH_HEADER;
                            chk_next   = '0;
                            crc_next   = CRC_INIT;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        res_valid        = 1'b0;
        res.payload_byte = '0;
        res.byte_valid   = 1'b0;
        res.record_done  = 1'b0;
        res.status       = ST_OK;
        if (fire)
        begin
            if (word.end_marker)
            begin
                res_valid       = 1'b1;
                res.record_done = 1'b1;
                res.status      = (phase_reg == PH_PAYLOAD) ? ST_CORRUPT : ST_EOL;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (hdr_last && (full_len == 32'd0))
                        begin
                            res_valid       = 1'b1;
                            res.record_done = 1'b1;
                            res.status      = (chk_reg == 32'd0) ? ST_OK : ST_CORRUPT;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        res_valid        = 1'b1;
                        res.payload_byte = word.data_byte;
                        res.byte_valid   = 1'b1;
                        if (pay_last)
                        begin
                            res.record_done = 1'b1;
                            res.status = ((~crc_upd) == chk_reg) ? ST_OK : ST_CORRUPT;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= '0;
            chk_reg     <= '0;
            left_reg    <= '0;
            crc_reg     <= CRC_INIT;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            chk_reg     <= chk_next;
            left_reg    <= left_next;
            crc_reg     <= crc_next;
        end
    end

endmodule

@@ design/lrc_out_stage.sv @@
// Result register for the log record CRC checker: holds a word until taken.
// Depends on lrc_pkg.
module lrc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic             res_valid,
    input  lrc_pkg::result_t res,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output lrc_pkg::result_t m_res
);
    import lrc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb
    begin
        if (take)
        begin
            valid_next = res_valid;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

@@ design/lrc_checker.sv @@
// Port-level checks for the log record CRC checker, bound to the top level.
// Depends on lrc_pkg and log_record_crc_checker_top.
module lrc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import lrc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_mid_record: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0] && (m_axis_tuser[2:1] == ST_OK))
        else $error("non-final word without payload byte or with status");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == 8'd0) && m_axis_tlast)
        else $error("status word carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tuser[2:1] == ST_OK) || (m_axis_tuser[2:1] == ST_CORRUPT))
        else $error("payload word with end-of-log or unknown status");

endmodule

bind log_record_crc_checker_top lrc_checker u_lrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/log_record_monitor.sv @@
`timescale 1ns / 1ps
// Monitor for the log record CRC checker: follows both stream channels, predicts
// each result word from the accepted log words and compares it field by field.
// Depends on lrc_pkg for the status codes, the CRC constants and the result layout.
module log_record_monitor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [2:0] m_axis_tuser,
    input  logic       m_axis_tlast,
    output int         failures,
    output int         pending,
    output int         results_seen,
    output int         ok_records,
    output int         corrupt_records,
    output int         log_ends
);
    import lrc_pkg::*;

    phase_t      phase;
    logic [2:0]  hdr_pos;
    logic [31:0] hdr_checksum;
    logic [31:0] remaining;
    logic [31:0] crc_reg;
    result_t     due_results[$];

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic restart_header();
        phase        = PH_HEADER;
        hdr_pos      = 3'd0;
        hdr_checksum = 32'd0;
        remaining    = 32'd0;
        crc_reg      = CRC_INIT;
    endtask

    task automatic parse_log_word(input logic [7:0] b, input logic last);
        result_t r;
        r.payload_byte = 8'd0;
        r.byte_valid   = 1'b0;
        r.record_done  = 1'b1;
        r.status       = ST_OK;
        if (last)
        begin
            r.status = (phase == PH_PAYLOAD) ? ST_CORRUPT : ST_EOL;
            restart_header();
            due_results.push_back(r);
        end
        else if (phase == PH_HEADER)
        begin
            if (!hdr_pos[2])
                hdr_checksum[8*hdr_pos[1:0] +: 8] = b;
            else
                remaining[8*hdr_pos[1:0] +: 8] = b;
            if (hdr_pos == 3'd7)
            begin
                crc_reg = CRC_INIT;
                hdr_pos = 3'd0;
                if (remaining == 32'd0)
                begin
                    r.status = (hdr_checksum == 32'd0) ? ST_OK : ST_CORRUPT;
                    restart_header();
                    due_results.push_back(r);
                end
                else
                begin
                    phase = PH_PAYLOAD;
                end
            end
            else
            begin
                hdr_pos = hdr_pos + 3'd1;
            end
        end
        else
        begin
            crc_reg        = crc32c_byte(crc_reg, b);
            remaining      = remaining - 32'd1;
            r.payload_byte = b;
            r.byte_valid   = 1'b1;
            if (remaining == 32'd0)
            begin
                r.status = (~crc_reg == hdr_checksum) ? ST_OK : ST_CORRUPT;
                restart_header();
            end
            else
            begin
                r.record_done = 1'b0;
            end
            due_results.push_back(r);
        end
    endtask

    task automatic compare_result();
        result_t want;
        if (due_results.size() == 0)
        begin
            $error("unexpected word: tdata %0h tuser %0h tlast %0b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            failures++;
        end
        else
        begin
            want = due_results.pop_front();
            results_seen++;
            if (m_axis_tdata !== want.payload_byte)
            begin
                $error("payload_byte: expected %0h, got %0h", want.payload_byte, m_axis_tdata);
                failures++;
            end
            if (m_axis_tuser[0] !== want.byte_valid)
            begin
                $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_axis_tuser[0]);
                failures++;
            end
            if (m_axis_tlast !== want.record_done)
            begin
                $error("record_done: expected %0b, got %0b", want.record_done, m_axis_tlast);
                failures++;
            end
            if (m_axis_tuser[2:1] !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:1]);
                failures++;
            end
            if (want.record_done)
            begin
                case (want.status)
                    ST_OK:   ok_records++;
                    ST_EOL:  log_ends++;
                    default: corrupt_records++;
                endcase
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_header();
            due_results.delete();
            failures        = 0;
            pending         = 0;
            results_seen    = 0;
            ok_records      = 0;
            corrupt_records = 0;
            log_ends        = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_result();
            if (s_axis_tvalid && s_axis_tready)
                parse_log_word(s_axis_tdata, s_axis_tlast);
            pending = due_results.size();
        end
    end

endmodule

@@ tb/tb_log_record_crc_checker_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the log record CRC checker: drives directed and random log
// streams under three idling phases and gives the verdict. Depends on lrc_pkg,
// log_record_monitor and the block's RTL.
module tb_log_record_crc_checker_top;
    import lrc_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_WORDS = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [7:0] byte_q_t[$];

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tready = 1'b0;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    int failures;
    int pending;
    int results_seen;
    int ok_records;
    int corrupt_records;
    int log_ends;

    int send_idle_pct = 34;
    int recv_idle_pct = 83;
    int words_in      = 0;
    int stall_cycles  = 0;

    log_record_crc_checker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    log_record_monitor monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .failures        (failures),
        .pending         (pending),
        .results_seen    (results_seen),
        .ok_records      (ok_records),
        .corrupt_records (corrupt_records),
        .log_ends        (log_ends)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $error("no word accepted for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [31:0] payload_crc32c(input byte_q_t bytes);
        logic [31:0] c;
        c = CRC_INIT;
        foreach (bytes[i])
        begin
            c ^= {24'd0, bytes[i]};
            repeat (8) c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return ~c;
    endfunction

    function automatic byte_q_t random_bytes(input int count);
        byte_q_t q;
        for (int i = 0; i < count; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_in++;
    endtask

    task automatic send_end_marker();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_bytes(input byte_q_t bytes);
        foreach (bytes[i])
            send_word(bytes[i], 1'b0);
    endtask

    task automatic send_header(input logic [31:0] checksum, input logic [31:0] length);
        for (int i = 0; i < 4; i++)
            send_word(checksum[8*i +: 8], 1'b0);
        for (int i = 0; i < 4; i++)
            send_word(length[8*i +: 8], 1'b0);
    endtask

    task automatic random_log(input int target);
        byte_q_t     payload;
        logic [31:0] length;
        logic [31:0] sum;
        int          kind;
        while (words_in < target)
        begin
            kind    = $urandom_range(0, 99);
            length  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
            payload = random_bytes(int'(length));
            sum     = payload_crc32c(payload);
            if (kind < 60)
            begin
                send_header(sum, length);
                send_bytes(payload);
            end
            else if (kind < 72)
            begin
                send_header(sum ^ (32'd1 << $urandom_range(0, 31)), length);
                send_bytes(payload);
            end
            else if (kind < 84)
            begin
                // cut the record short; the declared length always exceeds what is sent
                if ($urandom_range(0, 1) == 1)
                    send_header($urandom, $urandom | 32'h0000_0100);
                else
                    send_header(sum, length + 32'd1 + $urandom_range(0, 8));
                send_bytes(payload);
                send_end_marker();
            end
            else if (kind < 92)
            begin
                send_bytes(random_bytes($urandom_range(0, 7)));
                send_end_marker();
            end
            else
            begin
                send_bytes(random_bytes($urandom_range(1, 12)));
                send_end_marker();
            end
        end
    endtask

    initial
    begin
        int      start_words;
        byte_q_t one_ff;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        one_ff.push_back(8'hFF);
        send_end_marker();
        send_header(32'd0, 32'd0);
        send_header(32'hFFFF_FFFF, 32'd0);
        send_header(payload_crc32c(one_ff), 32'd1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_end_marker();

        start_words = words_in;
        random_log(start_words + RANDOM_WORDS / 3);
        send_idle_pct = 83;
        recv_idle_pct = 34;
        random_log(start_words + 2 * RANDOM_WORDS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_log(start_words + RANDOM_WORDS);
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $error("%0d result words never arrived", pending);
        $display("summary: %0d log words sent (%0d random) over three idling phases",
                 words_in, words_in - start_words);
        $display("summary: %0d result words checked, %0d records ok, %0d corrupt, %0d end of log",
                 results_seen, ok_records, corrupt_records, log_ends);
        if (failures == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/lrc_pkg.sv
design/lrc_in_stage.sv
design/lrc_parse.sv
design/lrc_out_stage.sv
design/log_record_crc_checker_top.sv
design/lrc_checker.sv
tb/log_record_monitor.sv
tb/tb_log_record_crc_checker_top.sv
